@@ rtl/cmct_pkg.sv @@
// shared types and constants of the circle mean color to temperature block
package cmct_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COLOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP   = 3'd5;

  localparam int SUM_W = 28;
  localparam int CNT_IN_W = 21;
  localparam int REM_W = 29;
  localparam int MEAN_STEPS = 8;
  localparam int MAC_STEPS = 6;
  localparam int QUO_W = 43;
  localparam int STEP_W = 6;

  typedef struct packed {
    logic              accept;
    logic              mean_init;
    logic              mean_step;
    logic              mac_step;
    logic              scale;
    logic              div_init;
    logic              div_step;
    logic              finish;
    logic [STEP_W-1:0] step;
  } cmct_cmd_t;

  typedef struct packed {
    logic win_end;
  } cmct_status_t;

endpackage

@@ rtl/cmct_ctrl.sv @@
// sequencer of pixel intake and end-of-window arithmetic
module cmct_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  cmct_pkg::cmct_status_t  status_i,
  output cmct_pkg::cmct_cmd_t     cmd_o,
  output logic                    busy_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DRAIN     = 4'd1;
  localparam logic [3:0] ST_MEAN_INIT = 4'd2;
  localparam logic [3:0] ST_MEAN_DIV  = 4'd3;
  localparam logic [3:0] ST_MAC       = 4'd4;
  localparam logic [3:0] ST_SCALE     = 4'd5;
  localparam logic [3:0] ST_DIV_INIT  = 4'd6;
  localparam logic [3:0] ST_DIV       = 4'd7;
  localparam logic [3:0] ST_FINISH    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [cmct_pkg::STEP_W-1:0] step_q, step_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cmd_o = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.win_end) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_MEAN_INIT;
      ST_MEAN_INIT: begin
        cmd_o.mean_init = 1'b1;
        step_d = '0;
        state_d = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        cmd_o.mean_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == cmct_pkg::STEP_W'(cmct_pkg::MEAN_STEPS - 1)) begin
          step_d = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == cmct_pkg::STEP_W'(cmct_pkg::MAC_STEPS - 1)) begin
          step_d = '0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == cmct_pkg::STEP_W'(cmct_pkg::QUO_W - 1)) begin
          step_d = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

endmodule

@@ rtl/cmct_dp.sv @@
// datapath: configuration, circle test, sums, mean and temperature arithmetic
module cmct_dp #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cmct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmct_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [7:0]                          pix_l_i,
  input  logic [7:0]                          pix_a_i,
  input  logic [7:0]                          pix_b_i,
  input  cmct_pkg::cmct_cmd_t                 cmd_i,
  output cmct_pkg::cmct_status_t              status_o,
  output logic                                done_o,
  output logic signed [23:0]                  temperature_q8_o,
  output logic [7:0]                          mean_l_o,
  output logic [7:0]                          mean_a_o,
  output logic [7:0]                          mean_b_o,
  output logic                                ref_degenerate_o,
  output logic                                saturated_o
);

  localparam int CNT_W = $clog2(MAX_SIDE);
  localparam int SIDE_W = CNT_W + 1;
  localparam int CW = (SIDE_W > 11) ? SIDE_W : 11;
  localparam int DX_W = SIDE_W + 1;
  localparam int SQ_W = 2 * DX_W;

  // configuration
  logic [10:0] win_width_q, win_height_q;
  logic [23:0] min_color_q, max_color_q;
  logic signed [12:0] min_temp_q, max_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_width_q <= 11'd64;
      win_height_q <= 11'd64;
      min_color_q <= '0;
      max_color_q <= '0;
      min_temp_q <= '0;
      max_temp_q <= 13'sd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmct_pkg::CFG_WIN_WIDTH:  win_width_q <= cfg_data_i[10:0];
        cmct_pkg::CFG_WIN_HEIGHT: win_height_q <= cfg_data_i[10:0];
        cmct_pkg::CFG_MIN_COLOR:  min_color_q <= cfg_data_i;
        cmct_pkg::CFG_MAX_COLOR:  max_color_q <= cfg_data_i;
        cmct_pkg::CFG_MIN_TEMP:   min_temp_q <= $signed(cfg_data_i[12:0]);
        cmct_pkg::CFG_MAX_TEMP:   max_temp_q <= $signed(cfg_data_i[12:0]);
        default: ;
      endcase
    end
  end

  // window geometry
  logic [CW-1:0] w_ext, h_ext;
  logic [SIDE_W-1:0] w_side, h_side, cx, cy, r;

  assign w_ext = CW'(win_width_q);
  assign h_ext = CW'(win_height_q);

  always_comb begin
    if (w_ext == '0) w_side = SIDE_W'(1);
    else if (w_ext > CW'(MAX_SIDE)) w_side = SIDE_W'(MAX_SIDE);
    else w_side = SIDE_W'(w_ext);
    if (h_ext == '0) h_side = SIDE_W'(1);
    else if (h_ext > CW'(MAX_SIDE)) h_side = SIDE_W'(MAX_SIDE);
    else h_side = SIDE_W'(h_ext);
  end

  assign cx = w_side >> 1;
  assign cy = h_side >> 1;
  assign r = (cx < cy) ? cx : cy;

  logic [CNT_W-1:0] col_q, row_q;
  logic last_col, last_row;

  assign last_col = {1'b0, col_q} >= (w_side - 1'b1);
  assign last_row = {1'b0, row_q} >= (h_side - 1'b1);
  assign status_o.win_end = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (!last_col) begin
        col_q <= col_q + 1'b1;
      end else begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 1'b1;
      end
    end
  end

  // circle test stage
  logic s1_vld_q;
  logic signed [DX_W-1:0] dx_q, dy_q;
  logic [SIDE_W-1:0] r_q;
  logic [7:0] p_l_q, p_a_q, p_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else s1_vld_q <= cmd_i.accept;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dx_q <= $signed({1'b0, cx}) - $signed({2'b00, col_q});
      dy_q <= $signed({1'b0, cy}) - $signed({2'b00, row_q});
      r_q <= r;
      p_l_q <= pix_l_i;
      p_a_q <= pix_a_i;
      p_b_q <= pix_b_i;
    end
  end

  logic signed [SQ_W-1:0] dx_w, dy_w;
  logic [SQ_W-1:0] dist2, r2;
  logic in_circle;

  assign dx_w = SQ_W'(dx_q);
  assign dy_w = SQ_W'(dy_q);
  assign dist2 = unsigned'(dx_w * dx_w) + unsigned'(dy_w * dy_w);
  assign r2 = SQ_W'(r_q) * SQ_W'(r_q);
  assign in_circle = dist2 <= r2;

  // sums
  logic [cmct_pkg::SUM_W-1:0] sum_l_q, sum_a_q, sum_b_q;
  logic [cmct_pkg::CNT_IN_W-1:0] in_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      in_cnt_q <= '0;
    end else if (cmd_i.mean_init) begin
      sum_l_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      in_cnt_q <= '0;
    end else if (s1_vld_q && in_circle) begin
      sum_l_q <= sum_l_q + cmct_pkg::SUM_W'(p_l_q);
      sum_a_q <= sum_a_q + cmct_pkg::SUM_W'(p_a_q);
      sum_b_q <= sum_b_q + cmct_pkg::SUM_W'(p_b_q);
      in_cnt_q <= in_cnt_q + 1'b1;
    end
  end

  // rounded means, one quotient bit per step for all channels
  logic [2:0][cmct_pkg::REM_W-1:0] rem_q;
  logic [2:0][7:0] mq_q;
  logic [cmct_pkg::CNT_IN_W-1:0] dvs_cnt_q;
  logic cnt_zero_q;
  logic [2:0] bit_idx;
  logic [cmct_pkg::REM_W-1:0] trial_dvs;
  logic [2:0][7:0] mean;

  assign bit_idx = 3'(cmct_pkg::MEAN_STEPS - 1) - cmd_i.step[2:0];
  assign trial_dvs = cmct_pkg::REM_W'(dvs_cnt_q) << bit_idx;

  always_comb begin
    for (int k = 0; k < 3; k++) mean[k] = cnt_zero_q ? 8'd0 : mq_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_init) begin
      rem_q[0] <= cmct_pkg::REM_W'(sum_l_q) + cmct_pkg::REM_W'(in_cnt_q >> 1);
      rem_q[1] <= cmct_pkg::REM_W'(sum_a_q) + cmct_pkg::REM_W'(in_cnt_q >> 1);
      rem_q[2] <= cmct_pkg::REM_W'(sum_b_q) + cmct_pkg::REM_W'(in_cnt_q >> 1);
      dvs_cnt_q <= in_cnt_q;
      cnt_zero_q <= (in_cnt_q == '0);
      mq_q <= '0;
    end else if (cmd_i.mean_step) begin
      for (int k = 0; k < 3; k++) begin
        if (rem_q[k] >= trial_dvs) begin
          rem_q[k] <= rem_q[k] - trial_dvs;
          mq_q[k] <= {mq_q[k][6:0], 1'b1};
        end else begin
          mq_q[k] <= {mq_q[k][6:0], 1'b0};
        end
      end
    end
  end

  // projection and axis length on one shared multiplier
  logic signed [8:0] dvec [3];
  logic signed [8:0] mvec [3];
  logic signed [8:0] mul_a, mul_b;
  logic signed [17:0] mul_p;
  logic signed [19:0] proj_q, len_q;
  logic [1:0] chan_sel;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvec[k] = $signed({1'b0, mean[k]}) - $signed({1'b0, min_color_q[8*(2-k) +: 8]});
      mvec[k] = $signed({1'b0, max_color_q[8*(2-k) +: 8]})
              - $signed({1'b0, min_color_q[8*(2-k) +: 8]});
    end
    chan_sel = (cmd_i.step < cmct_pkg::STEP_W'(3)) ? cmd_i.step[1:0]
             : 2'(cmd_i.step - cmct_pkg::STEP_W'(3));
    if (chan_sel == 2'd3) chan_sel = 2'd0;
    mul_a = (cmd_i.step < cmct_pkg::STEP_W'(3)) ? dvec[chan_sel] : mvec[chan_sel];
    mul_b = mvec[chan_sel];
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_init) begin
      proj_q <= '0;
      len_q <= '0;
    end else if (cmd_i.mac_step) begin
      if (cmd_i.step < cmct_pkg::STEP_W'(3)) proj_q <= proj_q + 20'(mul_p);
      else len_q <= len_q + 20'(mul_p);
    end
  end

  // scale by temperature span and divide by axis length
  logic signed [13:0] dt;
  logic signed [33:0] prod_q;
  logic neg_q;
  logic [cmct_pkg::QUO_W-1:0] numer_q, quo_q;
  logic [19:0] dvs_q;
  logic [18:0] drem_q;
  logic [33:0] mag;
  logic [19:0] rem_sh;
  logic ge;

  assign dt = 14'(max_temp_q) - 14'(min_temp_q);
  assign mag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
  assign rem_sh = {drem_q, numer_q[cmct_pkg::QUO_W-1]};
  assign ge = rem_sh >= dvs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      prod_q <= proj_q * dt;
    end
    if (cmd_i.div_init) begin
      neg_q <= prod_q[33];
      numer_q <= (cmct_pkg::QUO_W'(mag) << 9) + cmct_pkg::QUO_W'(len_q);
      dvs_q <= 20'(len_q) << 1;
      drem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      numer_q <= numer_q << 1;
      drem_q <= ge ? 19'(rem_sh - dvs_q) : rem_sh[18:0];
      quo_q <= {quo_q[cmct_pkg::QUO_W-2:0], ge};
    end
  end

  // final sum and clip
  logic signed [26:0] base, qs, tsum;
  logic big, degen;
  logic signed [23:0] temp_fin;
  logic sat_fin;

  assign degen = (len_q == '0);
  assign big = |quo_q[cmct_pkg::QUO_W-1:25];
  assign base = 27'(min_temp_q) <<< 8;
  assign qs = $signed({2'b00, quo_q[24:0]});
  assign tsum = neg_q ? base - qs : base + qs;

  always_comb begin
    sat_fin = 1'b0;
    temp_fin = 24'(tsum);
    if (degen) begin
      temp_fin = 24'(base);
    end else if (big) begin
      sat_fin = 1'b1;
      temp_fin = neg_q ? 24'sh800000 : 24'sh7FFFFF;
    end else if (tsum > 27'sd8388607) begin
      sat_fin = 1'b1;
      temp_fin = 24'sh7FFFFF;
    end else if (tsum < -27'sd8388608) begin
      sat_fin = 1'b1;
      temp_fin = 24'sh800000;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= cmd_i.finish;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      temperature_q8_o <= temp_fin;
      mean_l_o <= mean[0];
      mean_a_o <= mean[1];
      mean_b_o <= mean[2];
      ref_degenerate_o <= degen;
      saturated_o <= sat_fin;
    end
  end

  assign done_o = done_q;

endmodule

@@ rtl/circle_mean_color_to_temperature_top.sv @@
// top level: inscribed circle mean color mapped to a temperature
// a pixel item is taken each cycle while busy is low; a window's last item
// raises busy (drain, mean setup, 8-step mean divider, 6-step mac,
// scale, divider setup, 43-step quotient divider, finish), then done_o strobes once
// results cannot be stalled; reset restores the register defaults and
// clears counters and sums.
module circle_mean_color_to_temperature_top #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cmct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       pix_l_i,
  input  logic [7:0]                       pix_a_i,
  input  logic [7:0]                       pix_b_i,
  output logic                             done_o,
  output logic signed [23:0]               temperature_q8_o,
  output logic [7:0]                       mean_l_o,
  output logic [7:0]                       mean_a_o,
  output logic [7:0]                       mean_b_o,
  output logic                             ref_degenerate_o,
  output logic                             saturated_o
);

  cmct_pkg::cmct_cmd_t cmd;
  cmct_pkg::cmct_status_t status;

  cmct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  cmct_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .pix_l_i          (pix_l_i),
    .pix_a_i          (pix_a_i),
    .pix_b_i          (pix_b_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .done_o           (done_o),
    .temperature_q8_o (temperature_q8_o),
    .mean_l_o         (mean_l_o),
    .mean_a_o         (mean_a_o),
    .mean_b_o         (mean_b_o),
    .ref_degenerate_o (ref_degenerate_o),
    .saturated_o      (saturated_o)
  );

endmodule

@@ tb/sv/tb_circle_mean_color_to_temperature_top.sv @@
// testbench: circle mean color to temperature block against a built-in predictor
module tb_circle_mean_color_to_temperature_top;

  typedef struct packed {
    logic [7:0] l;
    logic [7:0] a;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] temp_q8;
    logic [7:0]         ml;
    logic [7:0]         ma;
    logic [7:0]         mb;
    logic               degen;
    logic               sat;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cmct_pkg::CFG_IDX_W-1:0] cfg_idx_i = cmct_pkg::CFG_WIN_WIDTH;
  logic [cmct_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] pix_l_i = '0, pix_a_i = '0, pix_b_i = '0;
  logic done_o;
  logic signed [23:0] temperature_q8_o;
  logic [7:0] mean_l_o, mean_a_o, mean_b_o;
  logic ref_degenerate_o, saturated_o;

  circle_mean_color_to_temperature_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow registers and accumulator state
  logic [10:0] sh_w = 11'd64, sh_h = 11'd64;
  logic [23:0] sh_minc = '0, sh_maxc = '0;
  logic [12:0] sh_tmin = '0, sh_tmax = 13'd100;
  int unsigned col_cnt, row_cnt, acc_l, acc_a, acc_b, inside_cnt;

  pixel_t   pixel_q[$];
  reading_t reading_q[$];
  int       errors = 0;
  bit       took = 0;
  int       burst_left = 0, gap_left = 0;

  function automatic int unsigned side(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic int unsigned rmean(int unsigned s, int unsigned c);
    if (c == 0) return 0;
    return ((longint'(s) + c / 2) / c) & 8'hFF;
  endfunction

  task automatic predict_temperature(pixel_t p);
    int unsigned w, h;
    longint cx, cy, r, dx, dy, m0, m1, m2, d0, d1, d2, proj, len, tmn, dt, num, mag, q, t;
    bit lc, lr;
    reading_t e;
    w = side(sh_w);
    h = side(sh_h);
    cx = w / 2;
    cy = h / 2;
    r = cx < cy ? cx : cy;
    dx = cx - col_cnt;
    dy = cy - row_cnt;
    lc = col_cnt >= w - 1;
    lr = row_cnt >= h - 1;
    if (dx * dx + dy * dy <= r * r) begin
      acc_l = (acc_l + p.l) & 28'hFFFFFFF;
      acc_a = (acc_a + p.a) & 28'hFFFFFFF;
      acc_b = (acc_b + p.b) & 28'hFFFFFFF;
      inside_cnt = (inside_cnt + 1) & 21'h1FFFFF;
    end
    if (!lc) begin
      col_cnt = (col_cnt + 1) & 10'h3FF;
      return;
    end
    col_cnt = 0;
    if (!lr) begin
      row_cnt = (row_cnt + 1) & 10'h3FF;
      return;
    end
    row_cnt = 0;
    e.ml = 8'(rmean(acc_l, inside_cnt));
    e.ma = 8'(rmean(acc_a, inside_cnt));
    e.mb = 8'(rmean(acc_b, inside_cnt));
    acc_l = 0; acc_a = 0; acc_b = 0; inside_cnt = 0;
    m0 = longint'(sh_maxc[23:16]) - sh_minc[23:16];
    m1 = longint'(sh_maxc[15:8]) - sh_minc[15:8];
    m2 = longint'(sh_maxc[7:0]) - sh_minc[7:0];
    d0 = longint'(e.ml) - sh_minc[23:16];
    d1 = longint'(e.ma) - sh_minc[15:8];
    d2 = longint'(e.mb) - sh_minc[7:0];
    proj = d0 * m0 + d1 * m1 + d2 * m2;
    len = m0 * m0 + m1 * m1 + m2 * m2;
    tmn = longint'($signed(sh_tmin));
    dt = longint'($signed(sh_tmax)) - tmn;
    e.degen = 0;
    e.sat = 0;
    if (len == 0) begin
      e.degen = 1;
      t = tmn * 256;
    end else begin
      num = proj * dt * 256;
      mag = num < 0 ? -num : num;
      q = (mag * 2 + len) / (2 * len);
      t = tmn * 256 + (num < 0 ? -q : q);
      if (t > 8388607) begin
        t = 8388607;
        e.sat = 1;
      end
      if (t < -8388608) begin
        t = -8388608;
        e.sat = 1;
      end
    end
    e.temp_q8 = t[23:0];
    reading_q.push_back(e);
  endtask

  // monitor
  always @(posedge clk_i) begin
    reading_t e;
    took = 0;
    if (rst_ni && done_o) begin
      if (reading_q.size() == 0) begin
        $error("result with no expected reading");
        errors++;
      end else begin
        e = reading_q.pop_front();
        if (temperature_q8_o !== e.temp_q8) begin
          $error("temperature_q8 exp %0d got %0d", e.temp_q8, temperature_q8_o);
          errors++;
        end
        if (mean_l_o !== e.ml) begin
          $error("mean_l exp %0d got %0d", e.ml, mean_l_o);
          errors++;
        end
        if (mean_a_o !== e.ma) begin
          $error("mean_a exp %0d got %0d", e.ma, mean_a_o);
          errors++;
        end
        if (mean_b_o !== e.mb) begin
          $error("mean_b exp %0d got %0d", e.mb, mean_b_o);
          errors++;
        end
        if (ref_degenerate_o !== e.degen) begin
          $error("ref_degenerate exp %0d got %0d", e.degen, ref_degenerate_o);
          errors++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated exp %0d got %0d", e.sat, saturated_o);
          errors++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      took = 1;
      predict_temperature({pix_l_i, pix_a_i, pix_b_i});
    end
  end

  // driver
  always @(negedge clk_i) begin
    pixel_t p;
    if (!(start && !took)) begin
      if (gap_left > 0 || pixel_q.size() == 0 || !rst_ni) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        p = pixel_q.pop_front();
        start <= 1'b1;
        pix_l_i <= p.l;
        pix_a_i <= p.a;
        pix_b_i <= p.b;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
  end

  task automatic write_reg(logic [cmct_pkg::CFG_IDX_W-1:0] idx,
                           logic [cmct_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      cmct_pkg::CFG_WIN_WIDTH:  sh_w = val[10:0];
      cmct_pkg::CFG_WIN_HEIGHT: sh_h = val[10:0];
      cmct_pkg::CFG_MIN_COLOR:  sh_minc = val;
      cmct_pkg::CFG_MAX_COLOR:  sh_maxc = val;
      cmct_pkg::CFG_MIN_TEMP:   sh_tmin = val[12:0];
      cmct_pkg::CFG_MAX_TEMP:   sh_tmax = val[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    wait (pixel_q.size() == 0 && !start);
    wait (reading_q.size() == 0);
    repeat (70) @(negedge clk_i);
  endtask

  task automatic push_random(int n);
    pixel_t p;
    repeat (n) begin
      p = 24'($urandom);
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? '1 : '0;
      pixel_q.push_back(p);
    end
  endtask

  task automatic set_map(logic [23:0] mn, logic [23:0] mx, logic [12:0] tl, logic [12:0] th);
    write_reg(cmct_pkg::CFG_MIN_COLOR, mn);
    write_reg(cmct_pkg::CFG_MAX_COLOR, mx);
    write_reg(cmct_pkg::CFG_MIN_TEMP, 24'(tl));
    write_reg(cmct_pkg::CFG_MAX_TEMP, 24'(th));
  endtask

  initial begin
    int unsigned w, h, tl, th;
    logic [23:0] mn, mx;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    // single pixel windows at the field extremes
    write_reg(cmct_pkg::CFG_WIN_WIDTH, 24'd1);
    write_reg(cmct_pkg::CFG_WIN_HEIGHT, 24'd1);
    set_map(24'h000000, 24'hFFFFFF, 13'h1000, 13'h0FFF);
    pixel_q.push_back('0);
    pixel_q.push_back('1);
    pixel_q.push_back({8'd255, 8'd0, 8'd128});
    settle();
    // equal references
    set_map(24'h123456, 24'h123456, 13'h1F00, 13'h0040);
    pixel_q.push_back({8'd9, 8'd200, 8'd77});
    settle();
    // clipping at both ends
    set_map(24'h000000, 24'h000001, 13'h1000, 13'h0FFF);
    pixel_q.push_back('1);
    settle();
    set_map(24'hFFFFFF, 24'hFFFFFE, 13'h0FFF, 13'h1000);
    pixel_q.push_back('0);
    settle();
    // size zero and oversize
    set_map(24'h204060, 24'hC08020, 13'h1FF6, 13'h0064);
    write_reg(cmct_pkg::CFG_WIN_WIDTH, 24'd0);
    write_reg(cmct_pkg::CFG_WIN_HEIGHT, 24'd0);
    push_random(2);
    settle();
    write_reg(cmct_pkg::CFG_WIN_WIDTH, 24'd2047);
    write_reg(cmct_pkg::CFG_WIN_HEIGHT, 24'd1);
    push_random(1024);
    settle();
    // size changed in the middle of a window
    write_reg(cmct_pkg::CFG_WIN_WIDTH, 24'd4);
    write_reg(cmct_pkg::CFG_WIN_HEIGHT, 24'd4);
    push_random(6);
    settle();
    write_reg(cmct_pkg::CFG_WIN_WIDTH, 24'd2);
    write_reg(cmct_pkg::CFG_WIN_HEIGHT, 24'd2);
    push_random(8);
    settle();
    // random phases of whole windows
    for (int ph = 0; ph < 20; ph++) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 24) : $urandom_range(1, 6);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 24) : $urandom_range(1, 6);
      write_reg(cmct_pkg::CFG_WIN_WIDTH, 24'(w));
      write_reg(cmct_pkg::CFG_WIN_HEIGHT, 24'(h));
      mn = 24'($urandom);
      mx = $urandom_range(0, 7) == 0 ? mn : 24'($urandom);
      tl = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 13'h1000 : 13'h0FFF) : $urandom;
      th = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 13'h1000 : 13'h0FFF) : $urandom;
      set_map(mn, mx, 13'(tl), 13'(th));
      w = side(11'(w));
      h = side(11'(h));
      push_random(w * h * ((40 / (w * h)) + 1));
      settle();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cmct_pkg.sv
rtl/cmct_ctrl.sv
rtl/cmct_dp.sv
rtl/circle_mean_color_to_temperature_top.sv
tb/sv/tb_circle_mean_color_to_temperature_top.sv
